>>> design/heu_pkg.sv
`timescale 1ns / 1ps
// Package for the HTML entity unescaper: controller states, command and
// status words, entity prefix codes and the prefix tables. No dependencies.
package heu_pkg;

  // Prefix codes: which part of an entity is held
  localparam logic [3:0] PS_NONE = 4'd0;
  localparam logic [3:0] PS_OPEN = 4'd1;   // "&"
  localparam logic [3:0] PS_L    = 4'd2;   // "&l"
  localparam logic [3:0] PS_LT   = 4'd3;   // "&lt"
  localparam logic [3:0] PS_G    = 4'd4;   // "&g"
  localparam logic [3:0] PS_GT   = 4'd5;   // "&gt"
  localparam logic [3:0] PS_Q    = 4'd6;   // "&q"
  localparam logic [3:0] PS_QU   = 4'd7;   // "&qu"
  localparam logic [3:0] PS_QUO  = 4'd8;   // "&quo"
  localparam logic [3:0] PS_QUOT = 4'd9;   // "&quot"
  localparam logic [3:0] PS_A    = 4'd10;  // "&a"
  localparam logic [3:0] PS_AM   = 4'd11;  // "&am"
  localparam logic [3:0] PS_AMP  = 4'd12;  // "&amp"

  // Characters
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_L    = 8'h6C;
  localparam logic [7:0] CH_G    = 8'h67;
  localparam logic [7:0] CH_Q    = 8'h71;
  localparam logic [7:0] CH_A    = 8'h61;
  localparam logic [7:0] CH_T    = 8'h74;
  localparam logic [7:0] CH_U    = 8'h75;
  localparam logic [7:0] CH_O    = 8'h6F;
  localparam logic [7:0] CH_M    = 8'h6D;
  localparam logic [7:0] CH_P    = 8'h70;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_HELD1,
    CS_CHAR,
    CS_HELD2
  } ctl_state_t;

  typedef enum logic [1:0] {
    SRC_DIRECT,
    SRC_HELD1,
    SRC_CHAR,
    SRC_HELD2
  } emit_src_t;

  typedef struct packed {
    logic      in_ready;
    logic      load;
    logic      emit;
    emit_src_t src;
    logic      idx_step;
    logic      idx_clr;
  } heu_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic simple;
    logic direct_has_x;
    logic len1_zero;
    logic end1;
    logic has_x;
    logic len2_zero;
    logic end2;
    logic prefix_zero;
  } heu_status_t;

  // Number of bytes held by a prefix code
  function automatic logic [2:0] held_len(input logic [3:0] code);
    case (code)
      PS_OPEN:                     held_len = 3'd1;
      PS_L, PS_G, PS_Q, PS_A:      held_len = 3'd2;
      PS_LT, PS_GT, PS_QU, PS_AM:  held_len = 3'd3;
      PS_QUO, PS_AMP:              held_len = 3'd4;
      PS_QUOT:                     held_len = 3'd5;
      default:                     held_len = 3'd0;
    endcase
  endfunction

  // Held text, first byte in the low bits
  function automatic logic [39:0] held_text(input logic [3:0] code);
    case (code)
      PS_OPEN:        held_text = {32'h0, CH_AMP};
      PS_L, PS_LT:    held_text = {16'h0, CH_T, CH_L, CH_AMP};
      PS_G, PS_GT:    held_text = {16'h0, CH_T, CH_G, CH_AMP};
      PS_Q, PS_QU, PS_QUO, PS_QUOT:
                      held_text = {CH_T, CH_O, CH_U, CH_Q, CH_AMP};
      PS_A, PS_AM, PS_AMP:
                      held_text = {8'h0, CH_P, CH_M, CH_A, CH_AMP};
      default:        held_text = '0;
    endcase
  endfunction

  // Byte that continues a prefix (codes past the opening '&')
  function automatic logic [7:0] prefix_expect(input logic [3:0] code);
    case (code)
      PS_L, PS_G, PS_QUO: prefix_expect = CH_T;
      PS_Q:               prefix_expect = CH_U;
      PS_QU:              prefix_expect = CH_O;
      PS_A:               prefix_expect = CH_M;
      PS_AM:              prefix_expect = CH_P;
      PS_LT, PS_GT, PS_QUOT, PS_AMP:
                          prefix_expect = CH_SEMI;
      default:            prefix_expect = 8'h00;
    endcase
  endfunction

  // Code after a continuing byte; none once the entity completes
  function automatic logic [3:0] prefix_next(input logic [3:0] code);
    case (code)
      PS_L:    prefix_next = PS_LT;
      PS_G:    prefix_next = PS_GT;
      PS_Q:    prefix_next = PS_QU;
      PS_QU:   prefix_next = PS_QUO;
      PS_QUO:  prefix_next = PS_QUOT;
      PS_A:    prefix_next = PS_AM;
      PS_AM:   prefix_next = PS_AMP;
      default: prefix_next = PS_NONE;
    endcase
  endfunction

  // Character that a completed entity stands for
  function automatic logic [7:0] prefix_emit(input logic [3:0] code);
    case (code)
      PS_LT:   prefix_emit = CH_LT;
      PS_GT:   prefix_emit = CH_GT;
      PS_QUOT: prefix_emit = CH_QUOT;
      PS_AMP:  prefix_emit = CH_AMP;
      default: prefix_emit = 8'h00;
    endcase
  endfunction

endpackage

>>> design/heu_if.sv
`timescale 1ns / 1ps
// Stream interfaces of the HTML entity unescaper: input and output channels
// with valid/ready handshake. No dependencies.
interface heu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface heu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

>>> design/heu_datapath.sv
`timescale 1ns / 1ps
// Datapath of the HTML entity unescaper: prefix state, per-word emission
// plan, held-byte index and output register. Depends on heu_pkg.
module heu_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  input  heu_pkg::heu_cmd_t    cmd,
  output heu_pkg::heu_status_t st,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_last
);
  import heu_pkg::*;

  logic [3:0] prefix;
  logic [3:0] plan_fs1;
  logic [3:0] plan_fs2;
  logic       plan_has_x;
  logic [7:0] plan_x;
  logic       plan_last;
  logic [2:0] idx;

  logic [3:0] s_eff;
  logic       matched;
  logic [3:0] ns;
  logic [3:0] live_fs1;
  logic [3:0] live_fs2;
  logic       live_has_x;
  logic [7:0] live_x;
  logic [3:0] prefix_next_val;
  logic [2:0] len1;
  logic [2:0] len2;
  logic [2:0] idx_inc;
  logic [39:0] text1;
  logic [39:0] text2;
  logic [7:0] emit_byte;
  logic       emit_last;

  // Work out what the incoming word causes
  always_comb begin
    s_eff      = (prefix > PS_AMP) ? PS_NONE : prefix;
    matched    = 1'b0;
    ns         = PS_NONE;
    live_fs1   = PS_NONE;
    live_has_x = 1'b0;
    live_x     = in_byte;
    if (s_eff == PS_OPEN) begin
      matched = 1'b1;
      case (in_byte)
        CH_L:    ns = PS_L;
        CH_G:    ns = PS_G;
        CH_Q:    ns = PS_Q;
        CH_A:    ns = PS_A;
        default: matched = 1'b0;
      endcase
    end else if (s_eff != PS_NONE && in_byte == prefix_expect(s_eff)) begin
      matched = 1'b1;
      ns      = prefix_next(s_eff);
      if (ns == PS_NONE) begin
        live_has_x = 1'b1;
        live_x     = prefix_emit(s_eff);
      end
    end
    if (!matched) begin
      live_fs1 = s_eff;
      if (in_byte == CH_AMP) begin
        ns = PS_OPEN;
      end else begin
        live_has_x = 1'b1;
        ns         = PS_NONE;
      end
    end
    live_fs2        = in_last ? ns : PS_NONE;
    prefix_next_val = in_last ? PS_NONE : ns;
  end

  // Load the plan and advance the prefix state on an accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      prefix <= PS_NONE;
    end else if (cmd.load) begin
      prefix <= prefix_next_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      plan_fs1   <= live_fs1;
      plan_fs2   <= live_fs2;
      plan_has_x <= live_has_x;
      plan_x     <= live_x;
      plan_last  <= in_last;
    end
  end

  // Step through the held bytes
  assign idx_inc = idx + 3'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.idx_clr || cmd.load) begin
      idx <= '0;
    end else if (cmd.idx_step) begin
      idx <= idx_inc;
    end
  end

  assign len1  = held_len(plan_fs1);
  assign len2  = held_len(plan_fs2);
  assign text1 = held_text(plan_fs1);
  assign text2 = held_text(plan_fs2);

  // Select the byte to emit and whether it closes the string
  always_comb begin
    case (cmd.src)
      SRC_DIRECT: begin
        emit_byte = live_x;
        emit_last = in_last;
      end
      SRC_HELD1: begin
        emit_byte = text1[{idx, 3'b000} +: 8];
        emit_last = plan_last && !plan_has_x && (len2 == 3'd0) && (idx_inc == len1);
      end
      SRC_CHAR: begin
        emit_byte = plan_x;
        emit_last = plan_last && (len2 == 3'd0);
      end
      SRC_HELD2: begin
        emit_byte = text2[{idx, 3'b000} +: 8];
        emit_last = plan_last && (idx_inc == len2);
      end
      default: begin
        emit_byte = live_x;
        emit_last = 1'b0;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte <= emit_byte;
      out_last <= emit_last;
    end
  end

  // Status back to the controller
  always_comb begin
    st.slot_free    = !out_valid || out_ready;
    st.simple       = (held_len(live_fs1) == 3'd0) && (held_len(live_fs2) == 3'd0);
    st.direct_has_x = live_has_x;
    st.len1_zero    = (len1 == 3'd0);
    st.end1         = (idx_inc == len1);
    st.has_x        = plan_has_x;
    st.len2_zero    = (len2 == 3'd0);
    st.end2         = (idx_inc == len2);
    st.prefix_zero  = (prefix == PS_NONE);
  end

endmodule

>>> design/heu_ctrl.sv
`timescale 1ns / 1ps
// Controller of the HTML entity unescaper: sequences the flush of a held
// prefix, the single character and the closing flush. Depends on heu_pkg.
module heu_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  heu_pkg::heu_status_t st,
  output heu_pkg::heu_cmd_t    cmd
);
  import heu_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      CS_IDLE: begin
        if (in_valid && st.slot_free && !st.simple) begin
          state_next = CS_HELD1;
        end
      end
      CS_HELD1: begin
        if (st.len1_zero || (st.slot_free && st.end1)) begin
          state_next = CS_CHAR;
        end
      end
      CS_CHAR: begin
        if (!st.has_x || st.slot_free) begin
          state_next = CS_HELD2;
        end
      end
      CS_HELD2: begin
        if (st.len2_zero || (st.slot_free && st.end2)) begin
          state_next = CS_IDLE;
        end
      end
      default: state_next = CS_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd          = '0;
    cmd.src      = SRC_DIRECT;
    case (state)
      CS_IDLE: begin
        cmd.in_ready = st.slot_free;
        cmd.load     = in_valid && st.slot_free;
        cmd.emit     = in_valid && st.slot_free && st.simple && st.direct_has_x;
      end
      CS_HELD1: begin
        cmd.src = SRC_HELD1;
        if (!st.len1_zero && st.slot_free) begin
          cmd.emit     = 1'b1;
          cmd.idx_step = 1'b1;
          cmd.idx_clr  = st.end1;
        end
      end
      CS_CHAR: begin
        cmd.src  = SRC_CHAR;
        cmd.emit = st.has_x && st.slot_free;
      end
      CS_HELD2: begin
        cmd.src = SRC_HELD2;
        if (!st.len2_zero && st.slot_free) begin
          cmd.emit     = 1'b1;
          cmd.idx_step = 1'b1;
          cmd.idx_clr  = st.end2;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

>>> design/html_entity_unescaper.sv
`timescale 1ns / 1ps
// HTML entity unescaper, top level. Replaces &lt; &gt; &quot; &amp; in a
// byte stream by < > " &.
//
// Channels: in_ch carries in_byte and in_last (final byte of a string);
// out_ch carries out_byte and out_last (final byte of the result string).
// A word moves when valid and ready are both high at a rising edge of clk.
// A word that needs no flush puts its result in the output
// register at the edge that takes it; such words move at one per cycle
// while the receiver keeps taking results. A word that breaks a held
// prefix, or the last word of a string that leaves a prefix held, then
// occupies the controller, with in_ch.ready low, while it flushes the held
// bytes (CS_HELD1), emits the character (CS_CHAR) and flushes the prefix
// that the string end leaves (CS_HELD2).
// The single output register sets the rate: a new word is taken in the
// same cycle the waiting result is taken. A stalled receiver holds the
// output register and, through it, stops input.
// Reset (rst, synchronous, active high) clears the held prefix, the
// controller and the output valid flag.
// Depends on heu_pkg, heu_if, heu_ctrl and heu_datapath.
module html_entity_unescaper (
  input logic       clk,
  input logic       rst,
  heu_in_if.sink    in_ch,
  heu_out_if.source out_ch
);
  import heu_pkg::*;

  heu_cmd_t    cmd;
  heu_status_t st;

  heu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .st       (st),
    .cmd      (cmd)
  );

  heu_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (in_ch.in_byte),
    .in_last   (in_ch.in_last),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.out_last)
  );

  assign in_ch.ready = cmd.in_ready;

  // Never overwrite a result that has not been taken
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> st.slot_free)
    else $error("emit into an occupied output register");

  // A string end leaves no prefix held
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && in_ch.in_last) |=> st.prefix_zero)
    else $error("prefix held after the last word");

  // A last word that needs no flush always yields a result marked last before the next word
  a_last_out: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && in_ch.in_last && st.simple) |=>
      (out_ch.valid && out_ch.out_last))
    else $error("last word gave no closing result");

endmodule
